// ===== hdl/psi_pkg.sv =====
package psi_pkg;

    // Default geometry of the vertex store and coordinate words
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_COORD_BITS   = 16;

    // Command codes carried by the op field
    typedef enum logic [1:0] {
        OP_CLEAR     = 2'd0,
        OP_APPEND    = 2'd1,
        OP_TRANSLATE = 2'd2,
        OP_QUERY     = 2'd3
    } op_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;      // input beat taken this cycle
        logic clear;       // empty the polygon
        logic append;      // store the beat as a new vertex
        logic walk_start;  // rewind the vertex walk
        logic query;       // walk is a segment query (with walk_start)
        logic walk;        // issue one vertex read
        logic load_out;    // capture the result into the output register
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic empty;       // no vertex stored
        logic last_read;   // the read issued this cycle ends the walk
        logic busy;        // reads or edge tests still in flight
    } dp_sts_t;

endpackage

// ===== hdl/polygon_segment_intersect.sv =====
// Polygon segment intersection: holds a polygon of up to MAX_VERTICES vertices
// and takes one command beat at a time (clear, append vertex, translate all
// vertices, query a segment), returning exactly one result beat per command.
// Clear and append, and a translate or query on an empty polygon, go straight
// to the result; otherwise the vertex store is walked one entry per cycle, and
// a query runs each edge through a three-stage orientation pipeline
// (differences, 17x17 products, sign compare). A new command is taken once
// the previous one has moved its result into the output register, even if
// that result is still stalled. An append to a full store is dropped and
// answers status 1; translation wraps in two's complement.
module polygon_segment_intersect
    import psi_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int COORD_BITS   = DEF_COORD_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   op,
    input  logic signed [COORD_BITS-1:0] first_x,
    input  logic signed [COORD_BITS-1:0] first_y,
    input  logic signed [COORD_BITS-1:0] second_x,
    input  logic signed [COORD_BITS-1:0] second_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         hit,
    output logic                         status
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequence commands
    psi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Store vertices and test edges
    psi_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .first_x  (first_x),
        .first_y  (first_y),
        .second_x (second_x),
        .second_y (second_y),
        .hit      (hit),
        .status   (status)
    );

endmodule

// ===== hdl/psi_ctrl.sv =====
module psi_ctrl
    import psi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  logic [1:0] op,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_take;
    logic   out_free;
    op_t    op_code;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign op_code   = op_t'(op);

    // Decode the beat and sequence the walk
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_FINISH;
                    unique case (op_code)
                        OP_CLEAR:  cmd.clear  = 1'b1;
                        OP_APPEND: cmd.append = 1'b1;
                        OP_TRANSLATE, OP_QUERY:
                        begin
                            cmd.walk_start = 1'b1;
                            cmd.query      = (op_code == OP_QUERY);
                            if (!sts.empty)
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        default: state_next = ST_FINISH;
                    endcase
                end
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.last_read)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A walk only runs over a non-empty polygon
    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> !sts.empty)
        else $error("vertex walk started on an empty polygon");

endmodule

// ===== hdl/psi_dp.sv =====
module psi_dp
    import psi_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int COORD_BITS   = DEF_COORD_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  dp_cmd_t                      cmd,
    output dp_sts_t                      sts,
    input  logic signed [COORD_BITS-1:0] first_x,
    input  logic signed [COORD_BITS-1:0] first_y,
    input  logic signed [COORD_BITS-1:0] second_x,
    input  logic signed [COORD_BITS-1:0] second_y,
    output logic                         hit,
    output logic                         status
);

    localparam int CB    = COORD_BITS;
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int D_W   = CB + 1;
    localparam int P_W   = 2 * D_W;

    typedef logic signed [CB-1:0]  coord_t;
    typedef logic signed [D_W-1:0] diff_t;
    typedef logic signed [P_W-1:0] prod_t;

    // Closed bounding-box test of point p against the box of a and b
    function automatic logic in_box(input coord_t ax, input coord_t ay,
                                    input coord_t bx, input coord_t by,
                                    input coord_t px, input coord_t py);
        coord_t lox;
        coord_t hix;
        coord_t loy;
        coord_t hiy;
        lox = (ax < bx) ? ax : bx;
        hix = (ax < bx) ? bx : ax;
        loy = (ay < by) ? ay : by;
        hiy = (ay < by) ? by : ay;
        return (px >= lox) && (px <= hix) && (py >= loy) && (py <= hiy);
    endfunction

    // Vertex store
    coord_t mem_x [MAX_VERTICES];
    coord_t mem_y [MAX_VERTICES];

    // Control registers
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] rd_cnt_reg;
    logic             query_reg;
    logic             rd_v_reg;
    logic             have_prev_reg;
    logic             s1_v_reg;
    logic             s2_v_reg;
    logic             hit_acc_reg;
    logic             full_reg;

    // Payload registers
    coord_t     sx_reg;
    coord_t     sy_reg;
    coord_t     ex_reg;
    coord_t     ey_reg;
    coord_t     rd_x_reg;
    coord_t     rd_y_reg;
    coord_t     prev_x_reg;
    coord_t     prev_y_reg;
    logic [IDX_W-1:0] wb_idx_reg;
    diff_t      es_y_reg;
    diff_t      es_x_reg;
    diff_t      pxe_reg;
    diff_t      pye_reg;
    diff_t      qxe_reg;
    diff_t      qye_reg;
    diff_t      qpy_reg;
    diff_t      qpx_reg;
    diff_t      sxq_reg;
    diff_t      syq_reg;
    diff_t      exq_reg;
    diff_t      eyq_reg;
    logic [3:0] box1_reg;
    logic [3:0] box2_reg;
    prod_t      op_a_reg;
    prod_t      op_b_reg;
    prod_t      oq_a_reg;
    prod_t      oq_b_reg;
    prod_t      os_a_reg;
    prod_t      os_b_reg;
    prod_t      oe_a_reg;
    prod_t      oe_b_reg;
    logic       hit_reg;
    logic       status_reg;

    logic             store_full;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    coord_t           wr_x;
    coord_t           wr_y;
    logic             edge_v;
    logic [3:0]       box_now;
    logic             op_pos, op_neg, oq_pos, oq_neg;
    logic             os_pos, os_neg, oe_pos, oe_neg;
    logic             edge_cross;
    logic             edge_touch;

    assign store_full = (count_reg == CNT_W'(MAX_VERTICES));

    // Read address: query walks wrap back to vertex zero on the extra read
    assign rd_addr = (rd_cnt_reg == count_reg) ? '0 : rd_cnt_reg[IDX_W-1:0];

    // Status toward the controller
    assign sts.empty     = (count_reg == '0);
    assign sts.last_read = query_reg ? (rd_cnt_reg == count_reg)
                                     : (CNT_W'(rd_cnt_reg + 1'b1) == count_reg);
    assign sts.busy      = rd_v_reg || s1_v_reg || s2_v_reg;

    // Write port: append at accept, translate write-back during the walk
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = wb_idx_reg;
        wr_x    = rd_x_reg + sx_reg;
        wr_y    = rd_y_reg + sy_reg;
        if (cmd.append)
        begin
            wr_en   = !store_full;
            wr_addr = count_reg[IDX_W-1:0];
            wr_x    = first_x;
            wr_y    = first_y;
        end
        else if (rd_v_reg && !query_reg)
        begin
            wr_en = 1'b1;
        end
    end

    // Write and read the vertex store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
        if (cmd.walk)
        begin
            rd_x_reg   <= mem_x[rd_addr];
            rd_y_reg   <= mem_y[rd_addr];
            wb_idx_reg <= rd_addr;
        end
    end

    // Form edge differences from previous and current vertex
    assign edge_v = rd_v_reg && query_reg && have_prev_reg;

    assign box_now[0] = in_box(sx_reg, sy_reg, ex_reg, ey_reg, prev_x_reg, prev_y_reg);
    assign box_now[1] = in_box(sx_reg, sy_reg, ex_reg, ey_reg, rd_x_reg, rd_y_reg);
    assign box_now[2] = in_box(prev_x_reg, prev_y_reg, rd_x_reg, rd_y_reg, sx_reg, sy_reg);
    assign box_now[3] = in_box(prev_x_reg, prev_y_reg, rd_x_reg, rd_y_reg, ex_reg, ey_reg);

    // Orientation signs and the edge verdict
    assign op_pos = op_a_reg > op_b_reg;
    assign op_neg = op_a_reg < op_b_reg;
    assign oq_pos = oq_a_reg > oq_b_reg;
    assign oq_neg = oq_a_reg < oq_b_reg;
    assign os_pos = os_a_reg > os_b_reg;
    assign os_neg = os_a_reg < os_b_reg;
    assign oe_pos = oe_a_reg > oe_b_reg;
    assign oe_neg = oe_a_reg < oe_b_reg;

    assign edge_cross = ((op_pos && oq_neg) || (op_neg && oq_pos)) &&
                        ((os_pos && oe_neg) || (os_neg && oe_pos));
    assign edge_touch = (!op_pos && !op_neg && box2_reg[0]) ||
                        (!oq_pos && !oq_neg && box2_reg[1]) ||
                        (!os_pos && !os_neg && box2_reg[2]) ||
                        (!oe_pos && !oe_neg && box2_reg[3]);

    // Datapath payload: beat capture, edge pipeline, result
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sx_reg <= first_x;
            sy_reg <= first_y;
            ex_reg <= second_x;
            ey_reg <= second_y;
        end
        if (rd_v_reg)
        begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
        end
        es_y_reg <= D_W'(ey_reg) - D_W'(sy_reg);
        es_x_reg <= D_W'(ex_reg) - D_W'(sx_reg);
        pxe_reg  <= D_W'(prev_x_reg) - D_W'(ex_reg);
        pye_reg  <= D_W'(prev_y_reg) - D_W'(ey_reg);
        qxe_reg  <= D_W'(rd_x_reg) - D_W'(ex_reg);
        qye_reg  <= D_W'(rd_y_reg) - D_W'(ey_reg);
        qpy_reg  <= D_W'(rd_y_reg) - D_W'(prev_y_reg);
        qpx_reg  <= D_W'(rd_x_reg) - D_W'(prev_x_reg);
        sxq_reg  <= D_W'(sx_reg) - D_W'(rd_x_reg);
        syq_reg  <= D_W'(sy_reg) - D_W'(rd_y_reg);
        exq_reg  <= D_W'(ex_reg) - D_W'(rd_x_reg);
        eyq_reg  <= D_W'(ey_reg) - D_W'(rd_y_reg);
        box1_reg <= box_now;
        op_a_reg <= P_W'(es_y_reg) * P_W'(pxe_reg);
        op_b_reg <= P_W'(es_x_reg) * P_W'(pye_reg);
        oq_a_reg <= P_W'(es_y_reg) * P_W'(qxe_reg);
        oq_b_reg <= P_W'(es_x_reg) * P_W'(qye_reg);
        os_a_reg <= P_W'(qpy_reg) * P_W'(sxq_reg);
        os_b_reg <= P_W'(qpx_reg) * P_W'(syq_reg);
        oe_a_reg <= P_W'(qpy_reg) * P_W'(exq_reg);
        oe_b_reg <= P_W'(qpx_reg) * P_W'(eyq_reg);
        box2_reg <= box1_reg;
        if (cmd.load_out)
        begin
            hit_reg    <= hit_acc_reg;
            status_reg <= full_reg;
        end
    end

    // Control: vertex count, walk counter, pipeline valids, hit flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_cnt_reg    <= '0;
            query_reg     <= 1'b0;
            rd_v_reg      <= 1'b0;
            have_prev_reg <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            hit_acc_reg   <= 1'b0;
            full_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.append && !store_full)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.accept)
            begin
                full_reg    <= cmd.append && store_full;
                hit_acc_reg <= 1'b0;
            end
            else if (s2_v_reg && (edge_cross || edge_touch))
            begin
                hit_acc_reg <= 1'b1;
            end
            if (cmd.walk_start)
            begin
                rd_cnt_reg    <= '0;
                query_reg     <= cmd.query;
                have_prev_reg <= 1'b0;
            end
            else
            begin
                if (cmd.walk)
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                end
                if (rd_v_reg)
                begin
                    have_prev_reg <= 1'b1;
                end
            end
            rd_v_reg <= cmd.walk;
            s1_v_reg <= edge_v;
            s2_v_reg <= s1_v_reg;
        end
    end

    assign hit    = hit_reg;
    assign status = status_reg;

    // A dropped append leaves the vertex count alone
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.append && store_full) |=> (count_reg == CNT_W'(MAX_VERTICES)))
        else $error("vertex count moved on a dropped append");

    // Write-back never lands on the entry being read
    a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && cmd.walk) |-> (wr_addr != rd_addr))
        else $error("store write and read collide");

    // The walk never reads past the stored vertices
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk |-> (rd_cnt_reg <= count_reg))
        else $error("vertex walk ran past the count");

    // No write-back or edge test survives the end of a walk into idle
    a_drain_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !sts.busy)
        else $error("result loaded while the walk is still in flight");

endmodule
